// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: sv/pphb_pkg.sv
// ----------------------------------------------------------------------------
// pphb_pkg
// Types, constants and byte script for the half-block terminal encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pphb_pkg;

  localparam int unsigned LINE_WIDTH_W = 13;
  localparam int unsigned IDX_W        = 6;

  // Script positions: both-opaque starts at 0, single-opaque at 19.
  localparam logic [IDX_W-1:0] IDX_BOTH_START   = 6'd0;
  localparam logic [IDX_W-1:0] IDX_SINGLE_START = 6'd19;
  localparam logic [IDX_W-1:0] IDX_END          = 6'd44;

  localparam logic [7:0] OPAQUE_LIMIT = 8'd128;

  localparam logic [7:0] CHR_ESC    = 8'h1B;
  localparam logic [7:0] CHR_LBRACK = 8'h5B;
  localparam logic [7:0] CHR_SEMI   = 8'h3B;
  localparam logic [7:0] CHR_M      = 8'h6D;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_TWO    = 8'h32;
  localparam logic [7:0] CHR_THREE  = 8'h33;
  localparam logic [7:0] CHR_FOUR   = 8'h34;
  localparam logic [7:0] CHR_EIGHT  = 8'h38;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] UTF_LEAD   = 8'hE2;
  localparam logic [7:0] UTF_MID    = 8'h96;
  localparam logic [7:0] UPPER_HALF = 8'h80;
  localparam logic [7:0] LOWER_HALF = 8'h84;

  typedef enum logic [1:0] {
    K_LIT  = 2'd0,
    K_DIG  = 2'd1,
    K_HALF = 2'd2
  } entry_kind_t;

  typedef enum logic [1:0] {
    COMP_R = 2'd0,
    COMP_G = 2'd1,
    COMP_B = 2'd2
  } comp_t;

  typedef enum logic [1:0] {
    DIG_H = 2'd0,
    DIG_T = 2'd1,
    DIG_O = 2'd2
  } dig_t;

  typedef struct packed {
    entry_kind_t kind;
    logic [7:0]  lit;
    comp_t       comp;
    dig_t        dig;
  } script_entry_t;

  typedef struct packed {
    logic [3:0] h;
    logic [3:0] t;
    logic [3:0] o;
  } dec3_t;

  typedef struct packed {
    logic load;
    logic emit_body;
    logic emit_lf;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic at_end;
    logic wrap;
  } status_t;

  // Three decimal digits of an 8-bit value; tens by reciprocal multiply.
  function automatic dec3_t dec3(input logic [7:0] v);
    dec3_t       d;
    logic [7:0]  r;
    logic [14:0] prod;
    logic [7:0]  t10;
    begin
      if (v >= 8'd200) begin
        d.h = 4'd2;
        r   = v - 8'd200;
      end else if (v >= 8'd100) begin
        d.h = 4'd1;
        r   = v - 8'd100;
      end else begin
        d.h = 4'd0;
        r   = v;
      end
      prod = 15'(r[6:0]) * 15'd205;
      d.t  = prod[14:11];
      t10  = {4'd0, d.t} * 8'd10;
      d.o  = 4'(r - t10);
      return d;
    end
  endfunction

  // ESC [ x 8 ; 2 ; where x is '4' for background, '3' for foreground.
  function automatic logic [7:0] sgr_prefix(input logic [2:0] pos, input logic bg);
    logic [7:0] c;
    begin
      unique case (pos)
        3'd0:    c = CHR_ESC;
        3'd1:    c = CHR_LBRACK;
        3'd2:    c = bg ? CHR_FOUR : CHR_THREE;
        3'd3:    c = CHR_EIGHT;
        3'd4:    c = CHR_SEMI;
        3'd5:    c = CHR_TWO;
        3'd6:    c = CHR_SEMI;
        default: c = CHR_SEMI;
      endcase
      return c;
    end
  endfunction

  // Color run "ddd;ddd;ddd" at offset 0..10.
  function automatic script_entry_t color_entry(input logic [3:0] off);
    script_entry_t e;
    begin
      e.lit  = CHR_SEMI;
      e.comp = comp_t'(off[3:2]);
      e.dig  = dig_t'(off[1:0]);
      e.kind = (off[1:0] == 2'd3) ? K_LIT : K_DIG;
      return e;
    end
  endfunction

  // Byte script of the both-opaque cell; single-opaque cells run its tail.
  function automatic script_entry_t script_entry(input logic [IDX_W-1:0] idx);
    script_entry_t e;
    begin
      e.kind = K_LIT;
      e.lit  = CHR_M;
      e.comp = COMP_R;
      e.dig  = DIG_H;
      priority if (idx < 6'd7) begin
        e.lit = sgr_prefix(idx[2:0], 1'b1);
      end else if (idx < 6'd18) begin
        e = color_entry(4'(idx - 6'd7));
      end else if (idx == 6'd18) begin
        e.lit = CHR_M;
      end else if (idx < 6'd26) begin
        e.lit = sgr_prefix(3'(idx - 6'd19), 1'b0);
      end else if (idx < 6'd37) begin
        e = color_entry(4'(idx - 6'd26));
      end else begin
        unique case (idx)
          6'd37:   e.lit = CHR_M;
          6'd38:   e.lit = UTF_LEAD;
          6'd39:   e.lit = UTF_MID;
          6'd40:   begin
            e.kind = K_HALF;
            e.lit  = UPPER_HALF;
          end
          6'd41:   e.lit = CHR_ESC;
          6'd42:   e.lit = CHR_LBRACK;
          6'd43:   e.lit = CHR_ZERO;
          default: e.lit = CHR_M;
        endcase
      end
      return e;
    end
  endfunction

endpackage

// File: sv/pphb_ctrl.sv
// ----------------------------------------------------------------------------
// pphb_ctrl
// Sequencer: takes a column, walks its byte script, then a line feed on wrap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pphb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pphb_pkg::status_t sts,
  output pphb_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BODY = 3'b010,
    S_LF   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_BODY;
        end
      end
      S_BODY: begin
        if (sts.out_free) begin
          cmd.emit_body = 1'b1;
          if (sts.at_end) begin
            state_next = sts.wrap ? S_LF : S_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      S_LF: begin
        if (sts.out_free) begin
          cmd.emit_lf = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/pphb_dpath.sv
// ----------------------------------------------------------------------------
// pphb_dpath
// Opacity and digit registers, script pointer, column counter, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pphb_dpath #(
  parameter int unsigned MAX_LINE_WIDTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pphb_pkg::LINE_WIDTH_W-1:0] cfg_data,
  input  logic [7:0]                        top_red,
  input  logic [7:0]                        top_green,
  input  logic [7:0]                        top_blue,
  input  logic [7:0]                        top_alpha,
  input  logic [7:0]                        bottom_red,
  input  logic [7:0]                        bottom_green,
  input  logic [7:0]                        bottom_blue,
  input  logic [7:0]                        bottom_alpha,
  input  pphb_pkg::cmd_t                    cmd,
  output pphb_pkg::status_t                 sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic                              last_byte
);

  localparam int unsigned CW   = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int unsigned CMPW = (CW + 1 > pphb_pkg::LINE_WIDTH_W) ?
                                 CW + 1 : pphb_pkg::LINE_WIDTH_W;
  localparam logic [CMPW-1:0] MAX_W = CMPW'(MAX_LINE_WIDTH);

  logic [pphb_pkg::LINE_WIDTH_W-1:0] line_width;
  logic [CW-1:0]                     col;
  logic                              wrap;
  logic                              top_op;
  logic                              bot_op;
  logic [pphb_pkg::IDX_W-1:0]        idx;
  pphb_pkg::dec3_t                   tdig [3];
  pphb_pkg::dec3_t                   bdig [3];

  logic [CMPW-1:0]       lw_ext;
  logic [CMPW-1:0]       eff_w;
  logic [CMPW-1:0]       col_inc;
  logic                  wrap_now;
  logic                  top_in;
  logic                  bot_in;
  pphb_pkg::script_entry_t ent;
  pphb_pkg::dec3_t       sel_dig;
  logic                  use_top;
  logic [3:0]            digit;
  logic [7:0]            body_byte;

  // Effective width: zero reads as one, clamped to the maximum.
  always_comb begin
    lw_ext = CMPW'(line_width);
    priority if (lw_ext == '0) begin
      eff_w = CMPW'(1);
    end else if (lw_ext > MAX_W) begin
      eff_w = MAX_W;
    end else begin
      eff_w = lw_ext;
    end
    col_inc  = CMPW'(col) + CMPW'(1);
    wrap_now = (col_inc >= eff_w);
  end

  assign top_in = (top_alpha > pphb_pkg::OPAQUE_LIMIT);
  assign bot_in = (bottom_alpha > pphb_pkg::OPAQUE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= pphb_pkg::LINE_WIDTH_W'(1);
      col        <= '0;
    end else begin
      if (cfg_we) begin
        line_width <= cfg_data;
      end
      if (cmd.load) begin
        col <= wrap_now ? '0 : col_inc[CW-1:0];
      end
    end
  end

  // Column capture: opacity, wrap decision, all decimal digits and script start.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      top_op  <= top_in;
      bot_op  <= bot_in;
      wrap    <= wrap_now;
      tdig[0] <= pphb_pkg::dec3(top_red);
      tdig[1] <= pphb_pkg::dec3(top_green);
      tdig[2] <= pphb_pkg::dec3(top_blue);
      bdig[0] <= pphb_pkg::dec3(bottom_red);
      bdig[1] <= pphb_pkg::dec3(bottom_green);
      bdig[2] <= pphb_pkg::dec3(bottom_blue);
      priority if (top_in && bot_in) begin
        idx <= pphb_pkg::IDX_BOTH_START;
      end else if (top_in || bot_in) begin
        idx <= pphb_pkg::IDX_SINGLE_START;
      end else begin
        idx <= pphb_pkg::IDX_END;
      end
    end else if (cmd.step) begin
      idx <= idx + pphb_pkg::IDX_W'(1);
    end
  end

  // Byte at the script pointer.
  always_comb begin
    ent     = pphb_pkg::script_entry(idx);
    use_top = (idx >= pphb_pkg::IDX_SINGLE_START) && top_op;
    unique case (ent.comp)
      pphb_pkg::COMP_R: sel_dig = use_top ? tdig[0] : bdig[0];
      pphb_pkg::COMP_G: sel_dig = use_top ? tdig[1] : bdig[1];
      default:          sel_dig = use_top ? tdig[2] : bdig[2];
    endcase
    unique case (ent.dig)
      pphb_pkg::DIG_H: digit = sel_dig.h;
      pphb_pkg::DIG_T: digit = sel_dig.t;
      default:         digit = sel_dig.o;
    endcase
    priority if (!top_op && !bot_op) begin
      body_byte = pphb_pkg::CHR_SPACE;
    end else begin
      unique case (ent.kind)
        pphb_pkg::K_DIG:  body_byte = pphb_pkg::CHR_ZERO | {4'd0, digit};
        pphb_pkg::K_HALF: body_byte = top_op ? pphb_pkg::UPPER_HALF
                                             : pphb_pkg::LOWER_HALF;
        default:          body_byte = ent.lit;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_body || cmd.emit_lf) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_lf) begin
      out_byte  <= pphb_pkg::CHR_LF;
      last_byte <= 1'b1;
    end else if (cmd.emit_body) begin
      out_byte  <= body_byte;
      last_byte <= (idx == pphb_pkg::IDX_END) && !wrap;
    end
  end

  assign sts.out_free = !out_valid || out_ready;
  assign sts.at_end   = (idx == pphb_pkg::IDX_END);
  assign sts.wrap     = wrap;

endmodule

// File: sv/pixel_pair_to_ansi_halfblock.sv
// ----------------------------------------------------------------------------
// pixel_pair_to_ansi_halfblock
// Encodes a column of two RGBA pixels as truecolor half-block terminal bytes.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    top_*, bottom_* (8 bits each)
// out       output     out_valid / out_ready  out_byte (8), last_byte (1)
// cfg       input      cfg_valid / cfg_ready  cfg_data = line_width (13)
//
// One output byte per cycle out of a single output register, within a column
// and while out_ready is high. A column is captured, then emits its bytes:
// 1 (space), 26 (one opaque pixel) or 45 (both opaque), plus a line feed on wrap.
// The script pointer in the datapath walks the bytes; the sequencer accepts
// the next column as soon as the last byte sits in the output register.
// A stall on out_ready freezes the walk. Synchronous reset clears the
// sequencer, output valid, column count and sets line_width to 1.
// cfg_ready is always high; writes are meant for idle periods.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pixel_pair_to_ansi_halfblock #(
  parameter int unsigned MAX_LINE_WIDTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        top_red,
  input  logic [7:0]                        top_green,
  input  logic [7:0]                        top_blue,
  input  logic [7:0]                        top_alpha,
  input  logic [7:0]                        bottom_red,
  input  logic [7:0]                        bottom_green,
  input  logic [7:0]                        bottom_blue,
  input  logic [7:0]                        bottom_alpha,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic                              last_byte,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pphb_pkg::LINE_WIDTH_W-1:0] cfg_data
);

  pphb_pkg::cmd_t    cmd;
  pphb_pkg::status_t sts;

  // Register write completes on any cfg transaction.
  assign cfg_ready = 1'b1;

  pphb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pphb_dpath #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .top_red      (top_red),
    .top_green    (top_green),
    .top_blue     (top_blue),
    .top_alpha    (top_alpha),
    .bottom_red   (bottom_red),
    .bottom_green (bottom_green),
    .bottom_blue  (bottom_blue),
    .bottom_alpha (bottom_alpha),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_byte    (last_byte)
  );

  // An accepted column always keeps the sequencer busy for the next cycle.
  `ASSERT_CLK(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready,
              "input accepted while previous column still in progress")

  // While idle, a byte still held in the output register closes its column.
  `ASSERT_CLK(a_idle_holds_last, clk, rst, (in_ready && out_valid) |-> last_byte,
              "idle with a non-final byte pending")

  // A line feed never appears inside a column's byte run.
  `ASSERT_CLK(a_lf_is_last, clk, rst,
              (out_valid && out_byte == pphb_pkg::CHR_LF) |-> last_byte,
              "line feed not marked as final byte")

endmodule
